// ----- rtl/core/lbrs_pkg.sv -----
`timescale 1ns / 1ps

package lbrs_pkg;

	localparam int DimW   = 8;
	localparam int NbW    = 10;
	localparam int MetW   = 32;
	localparam int TolW   = 16;
	localparam int OutRowW = 10;

	// one candidate row as it sits in the input register
	typedef struct packed {
		logic [DimW-1:0]   dim;
		logic [NbW-1:0]    nb;
		logic [MetW-1:0]   corr;
		logic [MetW-1:0]   abs_err;
		logic [MetW-1:0]   rms_err;
		logic              last;
	} item_t;

	// metrics and tie-break keys of the leading row
	typedef struct packed {
		logic [MetW-1:0]   corr;
		logic [MetW-1:0]   rms_err;
		logic [MetW-1:0]   abs_err;
		logic [NbW-1:0]    nb;
		logic [DimW-1:0]   dim;
	} metric_t;

	// outcome of comparing a row with the lead
	typedef struct packed {
		logic replace;   // row wins on metrics (or is first of set)
		logic tie_win;   // row wins only on neighbor count / dimension
	} dec_t;

	// lead after this row has been applied
	typedef struct packed {
		logic [DimW-1:0]    dim;
		logic [NbW-1:0]     nb;
		logic [OutRowW-1:0] row;
		logic               tie;
	} win_t;

endpackage

// ----- rtl/core/lbrs_compare.sv -----
`timescale 1ns / 1ps

module lbrs_compare (
	input  lbrs_pkg::item_t              item,
	input  lbrs_pkg::metric_t            lead,
	input  logic                         have_lead,
	input  logic [lbrs_pkg::TolW-1:0]    tol,
	output lbrs_pkg::dec_t               dec
);
	import lbrs_pkg::*;

	logic signed [MetW+1:0] dc, dr, da, tol_p, tol_n;
	logic c_better, c_eq, r_better, r_eq, a_better, a_eq;
	logic metric_win, key_win;

	always_comb begin
		// differences at full precision, two guard bits so nothing wraps
		dc    = {{2{item.corr[MetW-1]}}, item.corr} - {{2{lead.corr[MetW-1]}}, lead.corr};
		dr    = {2'b00, lead.rms_err} - {2'b00, item.rms_err};
		da    = {2'b00, lead.abs_err} - {2'b00, item.abs_err};
		tol_p = {{(MetW+2-TolW){1'b0}}, tol};
		tol_n = -tol_p;

		c_better = dc > tol_p;
		c_eq     = (dc <= tol_p) && (dc >= tol_n);
		r_better = dr > tol_p;
		r_eq     = (dr <= tol_p) && (dr >= tol_n);
		a_better = da > tol_p;
		a_eq     = (da <= tol_p) && (da >= tol_n);

		metric_win = c_better || (c_eq && r_better) || (c_eq && r_eq && a_better);
		key_win    = (item.nb < lead.nb) || ((item.nb == lead.nb) && (item.dim < lead.dim));

		dec.replace = !have_lead || metric_win;
		dec.tie_win = have_lead && !metric_win && c_eq && r_eq && a_eq && key_win;
	end

endmodule

// ----- rtl/core/lbrs_lead.sv -----
`timescale 1ns / 1ps

module lbrs_lead #(
	parameter int MAX_ROWS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  lbrs_pkg::item_t              item,
	input  logic [lbrs_pkg::TolW-1:0]    tol,
	output lbrs_pkg::win_t               win
);
	import lbrs_pkg::*;

	localparam int CW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RW = (CW > OutRowW) ? CW : OutRowW;

	logic            have_lead_q;
	metric_t         lead_q;
	logic [CW-1:0]   lead_row_q;
	logic [CW-1:0]   row_cnt_q;
	logic            tie_q;

	metric_t         lead_upd;
	logic [CW-1:0]   row_upd;
	logic            tie_upd;
	logic [CW-1:0]   cnt_inc;
	logic [RW-1:0]   row_ext;
	dec_t            dec;

	lbrs_compare u_compare (
		.item      (item),
		.lead      (lead_q),
		.have_lead (have_lead_q),
		.tol       (tol),
		.dec       (dec)
	);

	always_comb begin
		lead_upd = lead_q;
		row_upd  = lead_row_q;
		tie_upd  = tie_q;
		if (dec.replace) begin
			lead_upd.corr    = item.corr;
			lead_upd.rms_err = item.rms_err;
			lead_upd.abs_err = item.abs_err;
			lead_upd.nb      = item.nb;
			lead_upd.dim     = item.dim;
			row_upd          = row_cnt_q;
			tie_upd          = 1'b0;
		end else if (dec.tie_win) begin
			// metrics of the lead stay, only the keys move
			lead_upd.nb  = item.nb;
			lead_upd.dim = item.dim;
			row_upd      = row_cnt_q;
			tie_upd      = 1'b1;
		end

		// index saturates at the last row slot
		if (row_cnt_q < CW'(MAX_ROWS - 1)) begin
			cnt_inc = row_cnt_q + CW'(1);
		end else begin
			cnt_inc = row_cnt_q;
		end

		row_ext = RW'(row_upd);
		win.dim = lead_upd.dim;
		win.nb  = lead_upd.nb;
		win.row = row_ext[OutRowW-1:0];
		win.tie = tie_upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_lead_q <= 1'b0;
			lead_q      <= '0;
			lead_row_q  <= '0;
			row_cnt_q   <= '0;
			tie_q       <= 1'b0;
		end else if (adv) begin
			if (item.last) begin
				have_lead_q <= 1'b0;
				lead_q      <= '0;
				lead_row_q  <= '0;
				row_cnt_q   <= '0;
				tie_q       <= 1'b0;
			end else begin
				have_lead_q <= 1'b1;
				lead_q      <= lead_upd;
				lead_row_q  <= row_upd;
				row_cnt_q   <= cnt_inc;
				tie_q       <= tie_upd;
			end
		end
	end

endmodule

// ----- rtl/core/lexicographic_best_row_select_top.sv -----
`timescale 1ns / 1ps

// Best-row selector: takes one candidate row per cycle and keeps the lead
// by correlation, then RMS error, then absolute error (each within the
// tolerance register), then smaller neighbor count and dimension. A row is
// compared against the registered lead while it sits in the input register; a
// row marked last is held there until the result slot is free or draining,
// then produces one result request and resets the set state. Sustained rate is
// one row per cycle; input stalls only while a result is waiting and another last
// row is ready. tolerance should be written between sets. Row indices saturate at
// MAX_ROWS-1 and are reported as their low 10 bits.

module lexicographic_best_row_select_top #(
	parameter int MAX_ROWS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_write,
	input  logic [15:0]          cfg_data,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           embed_dim,
	input  logic [9:0]           neighbor_count,
	input  logic signed [31:0]   corr,
	input  logic [31:0]          abs_err,
	input  logic [31:0]          rms_err,
	input  logic                 last_row,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           opt_dim,
	output logic [9:0]           opt_neighbors,
	output logic [9:0]           opt_row_index,
	output logic                 tie_used
);
	import lbrs_pkg::*;

	logic [TolW-1:0] tol_q;
	logic            valid_s1;
	item_t           item_s1;
	logic            out_valid_q;
	win_t            res_q;
	win_t            win;
	logic            adv;
	logic            in_acc;

	// a last row may only move on when the result slot is free or draining
	assign adv      = valid_s1 && (!item_s1.last || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	lbrs_lead #(
		.MAX_ROWS (MAX_ROWS)
	) u_lead (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.tol    (tol_q),
		.win    (win)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				tol_q <= cfg_data;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv && item_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.dim     <= embed_dim;
			item_s1.nb      <= neighbor_count;
			item_s1.corr    <= corr;
			item_s1.abs_err <= abs_err;
			item_s1.rms_err <= rms_err;
			item_s1.last    <= last_row;
		end
		if (adv && item_s1.last) begin
			res_q <= win;
		end
	end

	assign out_valid     = out_valid_q;
	assign opt_dim       = res_q.dim;
	assign opt_neighbors = res_q.nb;
	assign opt_row_index = res_q.row;
	assign tie_used      = res_q.tie;

endmodule

// ----- rtl/core/lbrs_checker.sv -----
`timescale 1ns / 1ps

module lbrs_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_stall,
	input  logic         last_row,
	input  logic         out_valid,
	input  logic         out_stall,
	input  logic [7:0]   opt_dim,
	input  logic [9:0]   opt_neighbors,
	input  logic [9:0]   opt_row_index,
	input  logic         tie_used
);

	// a held result request keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(opt_dim)
			&& $stable(opt_neighbors) && $stable(opt_row_index) && $stable(tie_used))
		else $error("result changed while stalled");

	// input backpressure only comes from a blocked result slot
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with result slot free");

	// a fresh result follows an accepted last row
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && last_row, 2))
		else $error("result without a last row");

endmodule

bind lexicographic_best_row_select_top lbrs_checker u_lbrs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.last_row      (last_row),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.opt_dim       (opt_dim),
	.opt_neighbors (opt_neighbors),
	.opt_row_index (opt_row_index),
	.tie_used      (tie_used)
);

// ----- tb/lexicographic_best_row_select_top_tb.sv -----
`timescale 1ns / 1ps

module lexicographic_best_row_select_top_tb;
	import lbrs_pkg::*;

	localparam int MaxRows = 1024;
	localparam int QuietLimit = 2000;
	localparam int SettleCycles = 8;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         embed_dim = '0;
	logic [9:0]         neighbor_count = '0;
	logic signed [31:0] corr = '0;
	logic [31:0]        abs_err = '0;
	logic [31:0]        rms_err = '0;
	logic               last_row = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         opt_dim;
	logic [9:0]         opt_neighbors;
	logic [9:0]         opt_row_index;
	logic               tie_used;

	lexicographic_best_row_select_top #(
		.MAX_ROWS(MaxRows)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.embed_dim(embed_dim),
		.neighbor_count(neighbor_count),
		.corr(corr),
		.abs_err(abs_err),
		.rms_err(rms_err),
		.last_row(last_row),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.opt_dim(opt_dim),
		.opt_neighbors(opt_neighbors),
		.opt_row_index(opt_row_index),
		.tie_used(tie_used)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	item_t pending_rows[$];
	win_t  exp_winners[$];
	bit    idle_on = 1'b1;
	int    mismatches = 0;
	int    quiet_cycles = 0;
	int    in_gap = 0;
	int    stall_left = 0;

	// shadow of the selector state
	logic [15:0] tol_reg = '0;
	bit          lead_on = 1'b0;
	longint      best_corr = 0;
	longint      best_rms = 0;
	longint      best_abs = 0;
	int          best_nb = 0;
	int          best_dim = 0;
	int          best_row = 0;
	int          row_pos = 0;
	bit          tie_flag = 1'b0;

	function automatic void clear_lead();
		lead_on = 1'b0;
		best_corr = 0;
		best_rms = 0;
		best_abs = 0;
		best_nb = 0;
		best_dim = 0;
		best_row = 0;
		row_pos = 0;
		tie_flag = 1'b0;
	endfunction

	function automatic void take_lead(item_t r, longint c);
		lead_on = 1'b1;
		best_corr = c;
		best_rms = {32'd0, r.rms_err};
		best_abs = {32'd0, r.abs_err};
		best_nb = int'(r.nb);
		best_dim = int'(r.dim);
		best_row = row_pos;
		tie_flag = 1'b0;
	endfunction

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// fold one accepted row into the lead; a last row yields the winner
	function automatic void rank_row(item_t r);
		longint c, dc, dr, da, tol, rm, ab;
		win_t   w;
		c = longint'($signed(r.corr));
		rm = {32'd0, r.rms_err};
		ab = {32'd0, r.abs_err};
		tol = {48'd0, tol_reg};
		if (!lead_on) begin
			take_lead(r, c);
		end else begin
			dc = c - best_corr;
			dr = best_rms - rm;
			da = best_abs - ab;
			if (dc > tol || (mag(dc) <= tol && dr > tol) ||
					(mag(dc) <= tol && mag(dr) <= tol && da > tol)) begin
				take_lead(r, c);
			end else if (mag(dc) <= tol && mag(dr) <= tol && mag(da) <= tol) begin
				if (int'(r.nb) < best_nb ||
						(int'(r.nb) == best_nb && int'(r.dim) < best_dim)) begin
					best_nb = int'(r.nb);
					best_dim = int'(r.dim);
					best_row = row_pos;
					tie_flag = 1'b1;
				end
			end
		end
		if (r.last) begin
			w.dim = best_dim[7:0];
			w.nb = best_nb[9:0];
			w.row = best_row[9:0];
			w.tie = tie_flag;
			exp_winners.insert(exp_winners.size(), w);
			clear_lead();
		end else if (row_pos < MaxRows - 1) begin
			row_pos++;
		end
	endfunction

	// row request driver
	always @(posedge clk) begin : drive_rows
		item_t nxt;
		bit    fire;
		if (arst_n) begin
			fire = in_valid && !in_stall;
			if (fire)
				rank_row({embed_dim, neighbor_count, corr, abs_err, rms_err, last_row});
			if (!in_valid || fire) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_rows.size() > 0) begin
					nxt = pending_rows.pop_front();
					{embed_dim, neighbor_count, corr, abs_err, rms_err, last_row} <= nxt;
					in_valid <= 1'b1;
					if (idle_on && $urandom_range(0, 7) == 0)
						in_gap <= $urandom_range(1, 8);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result checker and output stall bursts
	always @(posedge clk) begin : check_results
		win_t got;
		win_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {opt_dim, opt_neighbors, opt_row_index, tie_used};
				if (exp_winners.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result dim %0d nb %0d row %0d tie %0d",
							$realtime, got.dim, got.nb, got.row, got.tie);
				end else begin
					want = exp_winners.pop_front();
					if (got.dim !== want.dim || got.nb !== want.nb ||
							got.row !== want.row || got.tie !== want.tie) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch exp dim %0d nb %0d row %0d tie %0d, %s%0d nb %0d row %0d tie %0d",
								$realtime, want.dim, want.nb, want.row, want.tie,
								"got dim ", got.dim, got.nb, got.row, got.tie);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left <= $urandom_range(0, 7);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QuietLimit) begin
				$display("FAIL lexicographic_best_row_select_top");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic void add_row(int d, int n, logic [31:0] c, logic [31:0] a,
			logic [31:0] rm, bit l);
		item_t r;
		r.dim = d[7:0];
		r.nb = n[9:0];
		r.corr = c;
		r.abs_err = a;
		r.rms_err = rm;
		r.last = l;
		pending_rows.insert(pending_rows.size(), r);
	endfunction

	function automatic item_t rand_row();
		item_t r;
		r.dim = 8'($urandom_range(0, 255));
		r.nb = 10'($urandom_range(0, 1023));
		r.corr = $urandom;
		r.abs_err = $urandom;
		r.rms_err = $urandom;
		r.last = 1'b0;
		return r;
	endfunction

	// keep a metric, or move it to the edges of the tolerance window, just outside them, or to a random offset near it
	function automatic logic [31:0] nudge(logic [31:0] v);
		longint t, d;
		t = {48'd0, tol_reg};
		case ($urandom_range(0, 5))
			0: d = 0;
			1: d = t;
			2: d = -t;
			3: d = t + 1;
			4: d = -t - 1;
			default: d = longint'($urandom_range(0, 2 * tol_reg + 4)) - (t + 2);
		endcase
		return v + d[31:0];
	endfunction

	task automatic gen_sets(int rows);
		int    left, len, i, mode;
		item_t base, r;
		left = rows;
		while (left > 0) begin
			len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
			base = rand_row();
			if ($urandom_range(0, 1))
				base.nb = 10'($urandom_range(0, 4));
			for (i = 0; i < len; i++) begin
				mode = $urandom_range(0, 9);
				r = base;
				if (mode < 2) begin
					r = rand_row();
				end else if (mode < 6 || mode == 9) begin
					r.corr = nudge(base.corr);
					r.rms_err = nudge(base.rms_err);
					r.abs_err = nudge(base.abs_err);
					if (mode != 9) begin
						r.nb = 10'($urandom_range(0, 1023));
						r.dim = 8'($urandom_range(0, 255));
					end
				end else begin
					// metrics tie exactly; only neighbors and dimension decide
					r.nb = $urandom_range(0, 1) ? base.nb : 10'($urandom_range(0, 4));
					r.dim = $urandom_range(0, 1) ? base.dim : 8'($urandom_range(0, 3));
				end
				r.last = (i == len - 1);
				pending_rows.insert(pending_rows.size(), r);
			end
			left -= len;
		end
	endtask

	// row index runs past MAX_ROWS-1 and the final row wins at the saturated index
	task automatic gen_long_set();
		int    i;
		item_t r;
		for (i = 0; i < MaxRows + 6; i++) begin
			r = rand_row();
			if (i == MaxRows + 5) begin
				r.corr = 32'h7FFF_FFFF;
				r.last = 1'b1;
			end
			pending_rows.insert(pending_rows.size(), r);
		end
	endtask

	task automatic wait_drained();
		while (pending_rows.size() != 0 || in_valid || exp_winners.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_tolerance(logic [15:0] v);
		wait_drained();
		repeat (SettleCycles) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= v;
		tol_reg = v;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// single-row sets at the field extremes
		add_row(255, 1023, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		add_row(0, 0, 32'h8000_0000, 32'h0, 32'h0, 1'b1);
		// each comparison stage in turn, then neighbor and dimension tie-breaks
		add_row(5, 5, 32'd0, 32'd100, 32'd100, 1'b0);
		add_row(5, 5, 32'd1, 32'd100, 32'd100, 1'b0);
		add_row(5, 5, 32'd1, 32'd100, 32'd99, 1'b0);
		add_row(5, 5, 32'd1, 32'd99, 32'd99, 1'b0);
		add_row(9, 4, 32'd1, 32'd99, 32'd99, 1'b0);
		add_row(3, 4, 32'd1, 32'd99, 32'd99, 1'b0);
		add_row(3, 4, 32'd1, 32'd99, 32'd99, 1'b0);
		add_row(0, 0, 32'h8000_0000, 32'd0, 32'd0, 1'b1);
		// tie flag set, then cleared by a strict win across the full corr range
		add_row(7, 7, 32'h8000_0000, 32'd50, 32'd50, 1'b0);
		add_row(7, 6, 32'h8000_0000, 32'd50, 32'd50, 1'b0);
		add_row(200, 900, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		// error extremes
		add_row(1, 1, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		add_row(2, 2, 32'd5, 32'hFFFF_FFFF, 32'h0, 1'b0);
		add_row(3, 3, 32'd5, 32'h0, 32'h0, 1'b1);

		set_tolerance(16'hFFFF);
		gen_sets(80);
		set_tolerance(16'h0000);
		gen_sets(80);
		gen_long_set();
		set_tolerance(16'($urandom_range(2, 65534)));
		gen_sets(80);
		set_tolerance(16'($urandom_range(1, 4)));
		gen_sets(80);
		set_tolerance(16'($urandom_range(0, 8)));
		idle_on = 1'b0;
		gen_sets(80);

		wait_drained();
		repeat (SettleCycles) @(posedge clk);
		if (mismatches == 0 && exp_winners.size() == 0)
			$display("PASS lexicographic_best_row_select_top");
		else
			$display("FAIL lexicographic_best_row_select_top");
		$finish;
	end

endmodule
